// ----- hdl/eaa_pkg.sv -----
package eaa_pkg;

  localparam int PixWidth   = 24;
  localparam int TableDepth = 256;
  localparam int FracBits   = 16;
  localparam int ThrWidth   = 9;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  localparam logic [1:0] TBL_CENTER     = 2'd0;
  localparam logic [1:0] TBL_DIAGONAL   = 2'd1;
  localparam logic [1:0] TBL_HORIZONTAL = 2'd2;
  localparam logic [1:0] TBL_VERTICAL   = 2'd3;

  localparam logic REG_SAME_THRESHOLD = 1'b0;
  localparam logic REG_DIFF_THRESHOLD = 1'b1;

  typedef struct packed {
    logic        command;
    logic [23:0] upper_pixel;
    logic [23:0] middle_pixel;
    logic [23:0] lower_pixel;
    logic        row_end;
    logic [1:0]  table_select;
    logic [7:0]  table_index;
    logic [31:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [23:0] out_pixel;
    logic        smoothed;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] w;
    logic [23:0] n;
    logic [23:0] s;
    logic [23:0] e;
  } cross_t;

endpackage

// ----- hdl/eaa_wtable.sv -----
module eaa_wtable #(
  parameter int WEIGHT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic                    re,
  input  logic [7:0]              addr,
  input  logic [WEIGHT_WIDTH-1:0] wdata,
  output logic [WEIGHT_WIDTH-1:0] rdata
);

  logic [WEIGHT_WIDTH-1:0] mem [eaa_pkg::TableDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hdl/eaa_check.sv -----
module eaa_check #(
  parameter int NB = 3
) (
  input  eaa_pkg::cross_t                 win,
  input  logic [eaa_pkg::ThrWidth-1:0]    same_threshold,
  input  logic [eaa_pkg::ThrWidth-1:0]    diff_threshold,
  output logic                            hit
);

  // pairs: 0 w-n, 1 w-s, 2 w-e, 3 e-n, 4 e-s
  logic [7:0] md [5];
  logic [23:0] pa [5];
  logic [23:0] pb [5];
  logic [4:0] same_p;
  logic [4:0] ge_p;
  logic [4:0] gt_p;

  always_comb begin
    pa[0] = win.w; pb[0] = win.n;
    pa[1] = win.w; pb[1] = win.s;
    pa[2] = win.w; pb[2] = win.e;
    pa[3] = win.e; pb[3] = win.n;
    pa[4] = win.e; pb[4] = win.s;
  end

  for (genvar p = 0; p < 5; p++) begin : g_pair
    always_comb begin
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] d;
      md[p] = 8'd0;
      for (int j = 0; j < NB; j++) begin
        x = pa[p][8*j +: 8];
        y = pb[p][8*j +: 8];
        d = (x > y) ? x - y : y - x;
        if (d > md[p]) md[p] = d;
      end
      same_p[p] = {1'b0, md[p]} < same_threshold;
      ge_p[p]   = {1'b0, md[p]} >= diff_threshold;
      gt_p[p]   = {1'b0, md[p]} > diff_threshold;
    end
  end

  assign hit = (same_p[0] && ge_p[1] && gt_p[2]) ||
               (same_p[1] && ge_p[0] && gt_p[2]) ||
               (same_p[3] && ge_p[4] && gt_p[2]) ||
               (same_p[4] && ge_p[3] && gt_p[2]);

endmodule

// ----- hdl/edge_antialias_3x3_rgb.sv -----
// Edge anti-aliasing filter over a sliding 3x3 window of packed pixels.
// Input channel pix_*: one item per transfer, either a pixel column (upper,
// middle, lower row) or a weight table write. Output channel res_*: result
// pixels in order, with run_last on the last result of each column.
// cfg_*: write same_threshold (index 0) or diff_threshold (index 1) while idle.
// A column whose inner pixel needs smoothing runs 4 reads per byte through
// the single-port weight tables, then a drain state and an emit state, plus
// a pass state when the row-end pixel also passes through. Other columns
// skip the reads; the second column of a row gives no result.
// A one-entry input register accepts the next column while the current one
// is being filtered; a four-entry result queue decouples the output side.
// When res_stall holds, the queue fills and the engine waits for room for
// two results before starting the next column, then pix_stall rises.
// Reset clears the window, the column count, the queue and the thresholds
// (both 40); the weight tables hold garbage until written.
module edge_antialias_3x3_rgb #(
  parameter int BYTES_PER_PIXEL = 3,
  parameter int WEIGHT_WIDTH    = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  eaa_pkg::in_item_t             pix_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output eaa_pkg::out_item_t            res_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [eaa_pkg::ThrWidth-1:0]  cfg_data
);

  localparam int NB    = (BYTES_PER_PIXEL > 3) ? 3 : BYTES_PER_PIXEL;
  localparam int STEPS = 4 * NB;
  localparam int SW    = $clog2(STEPS);
  localparam int JW    = (NB > 1) ? $clog2(NB) : 1;
  localparam int AW    = (WEIGHT_WIDTH + 4 > 24) ? WEIGHT_WIDTH + 4 : 24;
  localparam int QD    = 4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_LAST = 5'b00100,
    S_EMIT = 5'b01000,
    S_PASS = 5'b10000
  } state_t;

  state_t state;

  logic [eaa_pkg::ThrWidth-1:0] same_threshold;
  logic [eaa_pkg::ThrWidth-1:0] diff_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      same_threshold <= 9'd40;
      diff_threshold <= 9'd40;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eaa_pkg::REG_SAME_THRESHOLD: same_threshold <= cfg_data;
        eaa_pkg::REG_DIFF_THRESHOLD: diff_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // input holding register
  logic               hold_full;
  eaa_pkg::in_item_t  hold;
  logic               take;
  logic [2:0]         q_count;

  assign take      = hold_full && (state == S_IDLE) && (q_count <= 3'(QD - 2));
  assign pix_stall = hold_full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
    end else if (pix_valid && !pix_stall) begin
      hold_full <= 1'b1;
    end else if (take) begin
      hold_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && !pix_stall) begin
      hold <= pix_data;
    end
  end

  // window
  logic [23:0] older_upper, older_middle, older_lower;
  logic [23:0] newer_upper, newer_middle, newer_lower;
  logic [1:0]  columns_seen;
  logic        take_pix;
  logic        take_tbl;

  assign take_pix = take && (hold.command == eaa_pkg::CMD_PIXEL);
  assign take_tbl = take && (hold.command == eaa_pkg::CMD_TABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      older_upper  <= '0;
      older_middle <= '0;
      older_lower  <= '0;
      newer_upper  <= '0;
      newer_middle <= '0;
      newer_lower  <= '0;
      columns_seen <= 2'd0;
    end else if (take_pix) begin
      older_upper  <= newer_upper;
      older_middle <= newer_middle;
      older_lower  <= newer_lower;
      newer_upper  <= hold.upper_pixel;
      newer_middle <= hold.middle_pixel;
      newer_lower  <= hold.lower_pixel;
      if (hold.row_end) begin
        columns_seen <= 2'd0;
      end else if (columns_seen < 2'd2) begin
        columns_seen <= columns_seen + 2'd1;
      end
    end
  end

  eaa_pkg::cross_t cross_win;
  logic            hit;

  assign cross_win.w = older_middle;
  assign cross_win.n = newer_upper;
  assign cross_win.s = newer_lower;
  assign cross_win.e = hold.middle_pixel;

  eaa_check #(.NB(NB)) u_check (
    .win            (cross_win),
    .same_threshold (same_threshold),
    .diff_threshold (diff_threshold),
    .hit            (hit)
  );

  // latched 3x3 window of the pixel under work
  logic [23:0] nw, n, ne, w, c, e, sw, s, se;
  logic        filt_hit;
  logic        pend_pass;
  logic        pend_rowend;
  logic [23:0] pass_pix;
  logic [SW-1:0] step;

  always_ff @(posedge clk) begin
    if (take_pix) begin
      nw <= older_upper;  n <= newer_upper;  ne <= hold.upper_pixel;
      w  <= older_middle; c <= newer_middle; e  <= hold.middle_pixel;
      sw <= older_lower;  s <= newer_lower;  se <= hold.lower_pixel;
      filt_hit    <= hit;
      pend_pass   <= hold.row_end || (columns_seen == 2'd0);
      pend_rowend <= hold.row_end;
      pass_pix    <= hold.middle_pixel;
    end
  end

  // table address generation
  logic [JW-1:0] cur_j;
  logic [1:0]    cur_s;
  logic          rd_go;
  logic [7:0]    addr_c, addr_d, addr_h, addr_v;
  logic [7:0]    tbl_addr [4];
  logic [3:0]    tbl_we;
  logic [3:0]    tbl_re;
  logic [WEIGHT_WIDTH-1:0] tbl_rdata [4];

  assign cur_j = JW'(step >> 2);
  assign cur_s = step[1:0];
  assign rd_go = (state == S_READ);

  always_comb begin
    addr_c = c[8*cur_j +: 8];
    unique case (cur_s)
      2'd0:    addr_d = nw[8*cur_j +: 8];
      2'd1:    addr_d = ne[8*cur_j +: 8];
      2'd2:    addr_d = sw[8*cur_j +: 8];
      default: addr_d = se[8*cur_j +: 8];
    endcase
    addr_h = (cur_s == 2'd0) ? w[8*cur_j +: 8] : e[8*cur_j +: 8];
    addr_v = (cur_s == 2'd0) ? n[8*cur_j +: 8] : s[8*cur_j +: 8];
    for (int t = 0; t < 4; t++) begin
      tbl_we[t] = take_tbl && (hold.table_select == 2'(t));
    end
    tbl_re[eaa_pkg::TBL_CENTER]     = rd_go && (cur_s == 2'd0);
    tbl_re[eaa_pkg::TBL_DIAGONAL]   = rd_go;
    tbl_re[eaa_pkg::TBL_HORIZONTAL] = rd_go && (cur_s[1] == 1'b0);
    tbl_re[eaa_pkg::TBL_VERTICAL]   = rd_go && (cur_s[1] == 1'b0);
    if (take_tbl) begin
      for (int t = 0; t < 4; t++) begin
        tbl_addr[t] = hold.table_index;
      end
    end else begin
      tbl_addr[eaa_pkg::TBL_CENTER]     = addr_c;
      tbl_addr[eaa_pkg::TBL_DIAGONAL]   = addr_d;
      tbl_addr[eaa_pkg::TBL_HORIZONTAL] = addr_h;
      tbl_addr[eaa_pkg::TBL_VERTICAL]   = addr_v;
    end
  end

  for (genvar t = 0; t < 4; t++) begin : g_tbl
    eaa_wtable #(.WEIGHT_WIDTH(WEIGHT_WIDTH)) u_tbl (
      .clk   (clk),
      .we    (tbl_we[t]),
      .re    (tbl_re[t]),
      .addr  (tbl_addr[t]),
      .wdata (hold.table_value[WEIGHT_WIDTH-1:0]),
      .rdata (tbl_rdata[t])
    );
  end

  // read data is registered in the tables and arrives in the next cycle: remember which entries were read
  logic          rd_vld;
  logic [JW-1:0] rd_j;
  logic          rd_c, rd_hv;
  logic [AW-1:0] acc [NB];
  logic [AW-1:0] add_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_go;
    end
  end

  always_ff @(posedge clk) begin
    rd_j  <= cur_j;
    rd_c  <= tbl_re[eaa_pkg::TBL_CENTER];
    rd_hv <= tbl_re[eaa_pkg::TBL_HORIZONTAL];
  end

  always_comb begin
    add_sum = acc[rd_j] + AW'(tbl_rdata[eaa_pkg::TBL_DIAGONAL]);
    if (rd_c) begin
      add_sum = add_sum + AW'(tbl_rdata[eaa_pkg::TBL_CENTER]);
    end
    if (rd_hv) begin
      add_sum = add_sum + AW'(tbl_rdata[eaa_pkg::TBL_HORIZONTAL])
                        + AW'(tbl_rdata[eaa_pkg::TBL_VERTICAL]);
    end
  end

  always_ff @(posedge clk) begin
    if (take_pix) begin
      for (int j = 0; j < NB; j++) begin
        acc[j] <= '0;
      end
    end else if (rd_vld) begin
      acc[rd_j] <= add_sum;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (take_pix) begin
            if (columns_seen == 2'd2) begin
              state <= hit ? S_READ : S_EMIT;
            end else if (hold.row_end || columns_seen == 2'd0) begin
              state <= S_PASS;
            end
          end
        end
        S_READ: begin
          if (step == SW'(STEPS - 1)) begin
            state <= S_LAST;
          end else begin
            step <= step + SW'(1);
          end
        end
        S_LAST: state <= S_EMIT;
        S_EMIT: state <= pend_pass ? S_PASS : S_IDLE;
        S_PASS: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result queue
  eaa_pkg::out_item_t q_mem [QD];
  logic [1:0]         q_wr, q_rd;
  logic               q_push, q_pop;
  eaa_pkg::out_item_t q_in;
  logic [23:0]        filt_pix;

  always_comb begin
    filt_pix = '0;
    for (int j = 0; j < NB; j++) begin
      filt_pix[8*j +: 8] = acc[j][eaa_pkg::FracBits +: 8];
    end
  end

  assign q_push = (state == S_EMIT) || (state == S_PASS);
  assign q_pop  = res_valid && !res_stall;

  always_comb begin
    if (state == S_EMIT) begin
      q_in.out_pixel = filt_hit ? filt_pix : c;
      q_in.smoothed  = filt_hit;
      q_in.run_last  = !pend_rowend;
    end else begin
      q_in.out_pixel = pass_pix;
      q_in.smoothed  = 1'b0;
      q_in.run_last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= 2'd0;
      q_rd    <= 2'd0;
      q_count <= 3'd0;
    end else begin
      if (q_push) q_wr <= q_wr + 2'd1;
      if (q_pop)  q_rd <= q_rd + 2'd1;
      priority if (q_push && !q_pop) begin
        q_count <= q_count + 3'd1;
      end else if (q_pop && !q_push) begin
        q_count <= q_count - 3'd1;
      end
    end
  end

  assign res_valid = (q_count != 3'd0);
  assign res_data  = q_mem[q_rd];

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= 3'(QD))
    else $error("result queue overflow");

  a_room_reserved: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (q_count <= 3'(QD - 2)) || (q_pop))
    else $error("filter started without queue room");

  a_tbl_write_idle: assert property (@(posedge clk) disable iff (rst)
    take_tbl |=> (state == S_IDLE) && !rd_vld)
    else $error("table write overlapped a filter pass");

  a_read_one_shot: assert property (@(posedge clk) disable iff (rst)
    $fell(rd_go) |=> !rd_vld)
    else $error("read pipeline did not drain");

endmodule
